// File: hdl/frfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Face record field parser package
// Shared types, codes and field length table.
// ----------------------------------------------------------------------------
package frfp_pkg;

	localparam int unsigned QueueDepth = 4;

	typedef enum logic [4:0] {
		FC_VERSION     = 5'd0,
		FC_POINT_MAJOR = 5'd13,
		FC_POINT_MINOR = 5'd14,
		FC_PHOTO       = 5'd26,
		FC_TOO_SHORT   = 5'd27,
		FC_BAD_MAGIC   = 5'd28,
		FC_TRUNCATED   = 5'd29,
		FC_DONE        = 5'd30
	} field_code_t;

	localparam logic [4:0] PhVersion    = 5'd0;
	localparam logic [4:0] PhNumImages  = 5'd2;
	localparam logic [4:0] PhImgLen     = 5'd3;
	localparam logic [4:0] PhNumPoints  = 5'd4;
	localparam logic [4:0] PhPoseUnc    = 5'd11;
	localparam logic [4:0] PhPointType  = 5'd12;
	localparam logic [4:0] PhPointCode  = 5'd13;
	localparam logic [4:0] PhPointMinor = 5'd14;
	localparam logic [4:0] PhPointX     = 5'd15;
	localparam logic [4:0] PhPointRsv   = 5'd17;
	localparam logic [4:0] PhImgType    = 5'd18;
	localparam logic [4:0] PhQuality    = 5'd25;
	localparam logic [4:0] PhPhoto      = 5'd26;
	localparam logic [4:0] PhMagic      = 5'd28;
	localparam logic [4:0] PhIdle       = 5'd31;

	localparam logic [31:0] MinLen = 32'd46;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic [31:0] buffer_length;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  field_code;
		logic [31:0] field_value;
		logic [15:0] image_number;
		logic [15:0] point_number;
		logic        run_end;
	} out_item_t;

	// one step's results: up to two
	typedef struct packed {
		logic      two;
		out_item_t r0;
		out_item_t r1;
	} step_t;

	function automatic logic [2:0] field_len(input logic [4:0] ph);
		logic [2:0] r;
		unique case (ph)
			5'd0, 5'd1, 5'd3: r = 3'd4;
			5'd8, 5'd10, 5'd11: r = 3'd3;
			5'd2, 5'd4, 5'd9, 5'd15, 5'd16, 5'd17, 5'd20, 5'd21, 5'd24, 5'd25: r = 3'd2;
			5'd14: r = 3'd0;
			default: r = 3'd1;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] magic_byte(input logic [1:0] i);
		logic [7:0] r;
		unique case (i)
			2'd0: r = 8'h46;
			2'd1: r = 8'h41;
			default: r = 8'h43;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/frfp_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface frfp_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/frfp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Parses each accepted byte and pushes its results as one step entry.
// ----------------------------------------------------------------------------
module frfp_front import frfp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           push,
	output step_t          push_step,
	input  wire logic      full
);
	logic [4:0]  phase_q;
	logic [2:0]  bif_q;
	logic [31:0] asm_q, left_q, reclen_q, photo_q;
	logic [15:0] imgtot_q, img_q, pttot_q, pt_q;

	logic [4:0]  phase_d;
	logic [2:0]  bif_d;
	logic [31:0] asm_d, left_d, reclen_d, photo_d;
	logic [15:0] imgtot_d, img_d, pttot_d, pt_d;
	logic        fire;
	logic [1:0]  n;
	out_item_t   r0, r1;
	logic        done;
	logic [4:0]  ph;
	logic [7:0]  b;
	logic [2:0]  bif1;
	logic [33:0] raw;
	logic [15:0] imgn;

	assign in_ready = !full;
	assign fire = in_valid && in_ready;
	assign b = in_item.data_byte;

	always_comb begin
		phase_d = phase_q; bif_d = bif_q; asm_d = asm_q; left_d = left_q;
		reclen_d = reclen_q; photo_d = photo_q; imgtot_d = imgtot_q; img_d = img_q;
		pttot_d = pttot_q; pt_d = pt_q;
		n = 2'd0; r0 = '0; r1 = '0; done = 1'b0; ph = phase_q; bif1 = '0; raw = '0;
		imgn = '0;
		push = 1'b0;
		if (fire) begin
			if (in_item.first_byte) begin
				phase_d = PhMagic; bif_d = '0; asm_d = '0; reclen_d = '0; photo_d = '0;
				imgtot_d = '0; img_d = '0; pttot_d = '0; pt_d = '0;
				left_d = in_item.buffer_length;
				ph = PhMagic;
			end
			if (in_item.first_byte && in_item.buffer_length < MinLen) begin
				phase_d = PhIdle; left_d = '0;
				r0.field_code = FC_TOO_SHORT; n = 2'd1;
			end else if (ph != PhIdle) begin
				left_d = left_d - 32'd1;
				if (ph == PhMagic) begin
					if (bif_d < 3'd3 && b != magic_byte(bif_d[1:0])) begin
						phase_d = PhIdle;
						r0.field_code = FC_BAD_MAGIC; n = 2'd1;
					end else if (bif_d == 3'd3) begin
						bif_d = '0; phase_d = PhVersion;
					end else begin
						bif_d = bif_d + 3'd1;
					end
				end else if (ph == PhPhoto) begin
					r0.field_code = FC_PHOTO; r0.field_value = {24'd0, b};
					r0.image_number = img_q; n = 2'd1;
					photo_d = photo_q - 32'd1;
					if (photo_d == '0) begin
						img_d = img_q + 16'd1;
						if (img_d < imgtot_q) phase_d = PhImgLen;
						else begin phase_d = PhIdle; done = 1'b1; end
					end
				end else if (ph < PhPhoto && ph != PhPointMinor) begin
					asm_d = (bif_q == '0) ? {24'd0, b} : {asm_q[23:0], b};
					bif1 = bif_q + 3'd1;
					bif_d = bif1;
					if (bif1 >= field_len(ph)) begin
						bif_d = '0;
						imgn = (ph >= PhImgLen) ? img_q : 16'd0;
						r0.image_number = imgn; r1.image_number = imgn;
						if (ph >= PhPointType && ph <= PhPointRsv) begin
							r0.point_number = pt_q; r1.point_number = pt_q;
						end
						if (ph == PhPointCode) begin
							r0.field_code = FC_POINT_MAJOR; r0.field_value = {28'd0, b[7:4]};
							r1.field_code = FC_POINT_MINOR; r1.field_value = {28'd0, b[3:0]};
							n = 2'd2;
						end else begin
							r0.field_code = ph; r0.field_value = asm_d; n = 2'd1;
						end
						phase_d = ph + 5'd1;
						priority if (ph == PhNumImages) begin
							imgtot_d = asm_d[15:0]; img_d = '0;
							if (asm_d[15:0] == '0) begin phase_d = PhIdle; done = 1'b1; end
						end else if (ph == PhImgLen) begin
							reclen_d = asm_d;
						end else if (ph == PhNumPoints) begin
							pttot_d = asm_d[15:0]; pt_d = '0;
						end else if (ph == PhPoseUnc) begin
							phase_d = (pttot_q != '0) ? PhPointType : PhImgType;
						end else if (ph == PhPointCode) begin
							phase_d = PhPointX;
						end else if (ph == PhPointRsv) begin
							pt_d = pt_q + 16'd1;
							phase_d = (pt_d < pttot_q) ? PhPointType : PhImgType;
						end else if (ph == PhQuality) begin
							raw = {2'b00, reclen_q} - 34'd32 - {15'd0, pttot_q, 3'd0};
							if (raw[33] || raw > {2'b00, left_d}) raw = {2'b00, left_d};
							photo_d = raw[31:0];
							if (photo_d == '0) begin
								img_d = img_q + 16'd1;
								if (img_d < imgtot_q) phase_d = PhImgLen;
								else begin phase_d = PhIdle; done = 1'b1; end
							end else phase_d = PhPhoto;
						end else begin
						end
					end
				end else begin
					phase_d = PhIdle;
				end
				if (done) begin
					if (n == 2'd0) begin r0 = '0; r0.field_code = FC_DONE; end
					else begin r1 = '0; r1.field_code = FC_DONE; end
					n = n + 2'd1;
				end else if (left_d == '0 && phase_d != PhIdle) begin
					if (n == 2'd0) begin r0 = '0; r0.field_code = FC_TRUNCATED; end
					else begin r1 = '0; r1.field_code = FC_TRUNCATED; end
					n = (n == 2'd0) ? 2'd1 : 2'd2;
					phase_d = PhIdle;
				end
			end
			if (n == 2'd2) r1.run_end = 1'b1;
			else r0.run_end = 1'b1;
			push = (n != 2'd0);
		end
		push_step.two = (n == 2'd2);
		push_step.r0 = r0;
		push_step.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle; bif_q <= '0; asm_q <= '0; left_q <= '0; reclen_q <= '0;
			photo_q <= '0; imgtot_q <= '0; img_q <= '0; pttot_q <= '0; pt_q <= '0;
		end else begin
			phase_q <= phase_d; bif_q <= bif_d; asm_q <= asm_d; left_q <= left_d;
			reclen_q <= reclen_d; photo_q <= photo_d; imgtot_q <= imgtot_d;
			img_q <= img_d; pttot_q <= pttot_d; pt_q <= pt_d;
		end
	end
endmodule
`default_nettype wire

// File: hdl/frfp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Step queue read out directly as the output; splits two-result steps into items.
// ----------------------------------------------------------------------------
module frfp_back import frfp_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire step_t     push_step,
	output logic           full,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	step_t          mem_q [Depth];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           second_q;
	logic           pop;
	step_t          head;

	assign full = (cnt_q == (AW+1)'(Depth));
	assign head = mem_q[rd_q];
	assign out_valid = (cnt_q != '0);
	assign out_item = second_q ? head.r1 : head.r0;
	assign pop = out_valid && out_ready && (second_q || !head.two);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0; second_q <= 1'b0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
			if (pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
			if (out_valid && out_ready) second_q <= head.two && !second_q;
		end
	end
endmodule
`default_nettype wire

// File: hdl/face_record_field_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Face record field parser core
// Byte-serial parser for face image records.
// ----------------------------------------------------------------------------
// Input channel in_ch carries data_byte, first_byte and buffer_length; an item
// with first_byte set restarts parsing. Output channel out_ch carries one
// parsed field per item with field_code, field_value, image_number,
// point_number and run_end.
// The front end takes one byte per cycle while the queue has room and parses
// it in that cycle; its results are registered in a small step queue before
// they appear on out_ch. A byte yielding two results leaves as two items; the
// queue absorbs the extra item, so in_ch takes one byte per cycle back to back
// unless out_ch stalls.
// When out_ch stalls, the queue fills and in_ch.ready drops until a slot
// frees. Reset empties the queue and puts the parser into its idle phase,
// where bytes are dropped until a first byte arrives.
// ----------------------------------------------------------------------------
module face_record_field_parser_core import frfp_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	frfp_stream_if.sink              in_ch,
	frfp_stream_if.source            out_ch
);
	logic  push, full;
	step_t push_step;

	frfp_front u_front (
		.clk, .arst_n,
		.in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_item (in_ch.payload),
		.push, .push_step, .full
	);

	frfp_back #(.Depth(Depth)) u_back (
		.clk, .arst_n, .push, .push_step, .full,
		.out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_item (out_ch.payload)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && full) |-> 1'b0) else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.payload.field_code == FC_POINT_MAJOR) |-> !out_ch.payload.run_end)
		else $error("major code closing a step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.payload.first_byte
		 && in_ch.payload.buffer_length < MinLen) |-> push)
		else $error("short buffer not reported");
endmodule
`default_nettype wire

// File: dv/tb_face_record_field_parser_core.sv
// ----------------------------------------------------------------------------
// Face record field parser core testbench
// Drives byte streams of face records, both directed rows and random
// well-formed, truncated, short and corrupted records, with random sender
// bursts and receiver stalls, and checks every parsed field in order against
// a cycle-free predictor of the parser.
// ----------------------------------------------------------------------------
module tb_face_record_field_parser_core;
	import frfp_pkg::*;

	logic clk;
	logic arst_n;

	frfp_stream_if #(.payload_t(in_item_t))  in_ch ();
	frfp_stream_if #(.payload_t(out_item_t)) out_ch ();

	face_record_field_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// predictor state
	logic [4:0]  pr_phase;
	logic [2:0]  pr_bif;
	logic [31:0] pr_acc;
	logic [31:0] pr_left;
	logic [15:0] pr_imgs;
	logic [15:0] pr_img;
	logic [15:0] pr_pts;
	logic [15:0] pr_pt;
	logic [31:0] pr_reclen;
	logic [31:0] pr_photo;

	out_item_t expected_fields[$];
	int errors = 0;
	int row_errors;
	int fields_seen = 0;
	int records_sent;

	function automatic out_item_t mk(input logic [4:0] c, input logic [31:0] v,
			input logic [15:0] img, input logic [15:0] pt);
		out_item_t o;
		o.field_code = c;
		o.field_value = v;
		o.image_number = img;
		o.point_number = pt;
		o.run_end = 1'b0;
		return o;
	endfunction

	function automatic logic [2:0] flen(input logic [4:0] ph);
		case (ph)
			5'd0, 5'd1, 5'd3: return 3'd4;
			5'd8, 5'd10, 5'd11: return 3'd3;
			5'd2, 5'd4, 5'd9, 5'd15, 5'd16, 5'd17, 5'd20, 5'd21, 5'd24,
			5'd25: return 3'd2;
			5'd14: return 3'd0;
			default: return 3'd1;
		endcase
	endfunction

	task automatic clear_parser();
		pr_phase = PhIdle;
		pr_bif = '0;
		pr_acc = '0;
		pr_left = '0;
		pr_imgs = '0;
		pr_img = '0;
		pr_pts = '0;
		pr_pt = '0;
		pr_reclen = '0;
		pr_photo = '0;
	endtask

	task automatic next_image(output logic fin);
		pr_img = pr_img + 16'd1;
		if (pr_img < pr_imgs) begin
			pr_phase = PhImgLen;
			fin = 1'b0;
		end else begin
			pr_phase = PhIdle;
			fin = 1'b1;
		end
	endtask

	task automatic parse_byte(input in_item_t it);
		out_item_t res[2];
		int n;
		logic fin;
		logic [4:0] ph;
		logic [31:0] v;
		logic [15:0] img;
		logic [15:0] pt;
		logic signed [63:0] raw;
		logic [7:0] b;
		n = 0;
		fin = 1'b0;
		b = it.data_byte;
		if (it.first_byte) begin
			clear_parser();
			if (it.buffer_length < MinLen) begin
				res[0] = mk(FC_TOO_SHORT, '0, '0, '0);
				res[0].run_end = 1'b1;
				expected_fields.insert(expected_fields.size(), res[0]);
				return;
			end
			pr_left = it.buffer_length;
			pr_phase = PhMagic;
		end else if (pr_phase == PhIdle) begin
			return;
		end
		pr_left = pr_left - 32'd1;
		if (pr_phase == PhMagic) begin
			if (pr_bif < 3 && b != magic_byte(pr_bif[1:0])) begin
				pr_phase = PhIdle;
				res[0] = mk(FC_BAD_MAGIC, '0, '0, '0);
				res[0].run_end = 1'b1;
				expected_fields.insert(expected_fields.size(), res[0]);
				return;
			end
			pr_bif = pr_bif + 3'd1;
			if (pr_bif >= 4) begin
				pr_bif = '0;
				pr_phase = PhVersion;
			end
		end else if (pr_phase == PhPhoto) begin
			res[n++] = mk(FC_PHOTO, {24'd0, b}, pr_img, '0);
			pr_photo = pr_photo - 32'd1;
			if (pr_photo == 0) next_image(fin);
		end else if (pr_phase < PhPhoto && pr_phase != PhPointMinor) begin
			ph = pr_phase;
			pr_acc = (pr_bif == 0) ? {24'd0, b} : {pr_acc[23:0], b};
			pr_bif = pr_bif + 3'd1;
			if (pr_bif >= flen(ph)) begin
				v = pr_acc;
				img = (ph >= PhImgLen) ? pr_img : 16'd0;
				pt = (ph >= PhPointType && ph <= PhPointRsv) ? pr_pt : 16'd0;
				pr_bif = '0;
				if (ph == PhPointCode) begin
					res[n++] = mk(FC_POINT_MAJOR, {28'd0, b[7:4]}, img, pt);
					res[n++] = mk(FC_POINT_MINOR, {28'd0, b[3:0]}, img, pt);
				end else begin
					res[n++] = mk(ph, v, img, pt);
				end
				case (ph)
					PhNumImages: begin
						pr_imgs = v[15:0];
						pr_img = '0;
						if (pr_imgs == 0) begin
							pr_phase = PhIdle;
							fin = 1'b1;
						end else begin
							pr_phase = PhImgLen;
						end
					end
					PhImgLen: begin
						pr_reclen = v;
						pr_phase = PhNumPoints;
					end
					PhNumPoints: begin
						pr_pts = v[15:0];
						pr_pt = '0;
						pr_phase = ph + 5'd1;
					end
					PhPoseUnc: pr_phase = (pr_pts > 0) ? PhPointType : PhImgType;
					PhPointCode: pr_phase = PhPointX;
					PhPointRsv: begin
						pr_pt = pr_pt + 16'd1;
						pr_phase = (pr_pt < pr_pts) ? PhPointType : PhImgType;
					end
					PhQuality: begin
						raw = $signed({32'd0, pr_reclen}) - 64'sd32
							- 64'sd8 * $signed({48'd0, pr_pts});
						if (raw < 0 || raw > $signed({32'd0, pr_left}))
							raw = $signed({32'd0, pr_left});
						pr_photo = raw[31:0];
						if (pr_photo == 0) next_image(fin);
						else pr_phase = PhPhoto;
					end
					default: pr_phase = ph + 5'd1;
				endcase
			end
		end else begin
			pr_phase = PhIdle;
		end
		if (fin) begin
			res[n++] = mk(FC_DONE, '0, '0, '0);
		end else if (pr_left == 0 && pr_phase != PhIdle) begin
			if (n >= 2) n = 1;
			res[n++] = mk(FC_TRUNCATED, '0, '0, '0);
			pr_phase = PhIdle;
		end
		if (n > 0) res[n-1].run_end = 1'b1;
		for (int k = 0; k < n; k++) expected_fields.insert(expected_fields.size(), res[k]);
	endtask

	// directed table: byte, first flag, length, typed code of last predicted result or -1
	typedef struct {
		logic [7:0]  b;
		logic        f;
		logic [31:0] len;
		int          code;
	} row_t;

	row_t rows[$];

	task automatic add_row(input logic [7:0] b, input logic f, input logic [31:0] len,
			input int code);
		row_t r;
		r.b = b;
		r.f = f;
		r.len = len;
		r.code = code;
		rows.insert(rows.size(), r);
	endtask

	// stimulus stream
	in_item_t stim[$];
	int typed_code[$];

	task automatic push_byte(input logic [7:0] b, input logic f, input logic [31:0] len);
		in_item_t it;
		it.data_byte = b;
		it.first_byte = f;
		it.buffer_length = len;
		stim.insert(stim.size(), it);
		typed_code.insert(typed_code.size(), -1);
	endtask

	task automatic push_be(input logic [31:0] v, input int nb);
		for (int k = nb - 1; k >= 0; k--) push_byte(v[8*k +: 8], 1'b0, $urandom);
	endtask

	// one random record; well formed most of the time
	task automatic make_record();
		logic [15:0] imgs;
		logic [15:0] pts;
		int total;
		int photo;
		int cut;
		int q0;
		logic [31:0] blen;
		logic [31:0] reclen;
		int mode;
		mode = $urandom_range(0, 19);
		imgs = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 2));
		q0 = stim.size();
		push_byte(8'h46, 1'b1, 32'd0);
		push_byte(8'h41, 1'b0, $urandom);
		push_byte(8'h43, 1'b0, $urandom);
		push_byte(8'($urandom), 1'b0, $urandom);
		push_be($urandom, 4);
		push_be($urandom, 4);
		push_be({16'd0, imgs}, 2);
		for (int i = 0; i < imgs; i++) begin
			pts = 16'($urandom_range(0, 3));
			photo = $urandom_range(0, 12);
			reclen = ($urandom_range(0, 7) == 0) ? $urandom : 32'(32 + 8 * pts + photo);
			push_be(reclen, 4);
			push_be({16'd0, pts}, 2);
			for (int k = 0; k < 15; k++) push_byte(8'($urandom), 1'b0, $urandom);
			for (int p = 0; p < pts; p++)
				for (int k = 0; k < 8; k++) push_byte(8'($urandom), 1'b0, $urandom);
			for (int k = 0; k < 12; k++) push_byte(8'($urandom), 1'b0, $urandom);
			for (int k = 0; k < photo; k++) push_byte(8'($urandom), 1'b0, $urandom);
		end
		total = stim.size() - q0;
		blen = 32'(total);
		if (mode < 3) begin
			cut = $urandom_range(46, total > 46 ? total : 46);
			blen = 32'(cut);
		end else if (mode == 3) begin
			blen = $urandom_range(0, 45);
		end else if (mode == 4) begin
			stim[q0 + $urandom_range(0, 2)].data_byte = 8'($urandom);
		end else if (mode == 5) begin
			blen = 32'(total) + $urandom_range(0, 30);
		end else if (mode == 6) begin
			blen = $urandom;
		end
		if (blen < MinLen && mode != 3) blen = MinLen;
		stim[q0].buffer_length = blen;
		// trailing noise between records
		for (int k = $urandom_range(0, 3); k > 0; k--)
			push_byte(8'($urandom), 1'b0, $urandom);
		records_sent++;
	endtask

	int idle_cycles;
	logic sender_hold;
	int done_stim;

	// input driver
	initial begin
		int burst;
		int gap;
		int idx;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		arst_n = 1'b0;
		row_errors = 0;
		records_sent = 0;
		sender_hold = 1'b0;
		done_stim = 0;
		clear_parser();

		// directed rows
		add_row(8'h46, 1'b1, 32'd0, FC_TOO_SHORT);
		add_row(8'h46, 1'b1, 32'd45, FC_TOO_SHORT);
		add_row(8'hFF, 1'b0, 32'hFFFF_FFFF, -1);
		add_row(8'h00, 1'b1, 32'd46, FC_BAD_MAGIC);
		add_row(8'h46, 1'b1, 32'hFFFF_FFFF, -1);
		add_row(8'h00, 1'b0, 32'd0, FC_BAD_MAGIC);
		add_row(8'h46, 1'b1, 32'd46, -1);
		add_row(8'h41, 1'b0, 32'd0, -1);
		add_row(8'hFF, 1'b0, 32'd0, FC_BAD_MAGIC);
		add_row(8'h46, 1'b1, 32'd46, -1);
		add_row(8'h41, 1'b0, 32'd0, -1);
		add_row(8'h43, 1'b0, 32'd0, -1);
		add_row(8'hFF, 1'b0, 32'd0, -1);
		for (int k = 0; k < 8; k++) add_row(8'hFF, 1'b0, 32'd0, -1);
		add_row(8'h00, 1'b0, 32'd0, -1);
		add_row(8'h00, 1'b0, 32'd0, FC_DONE);
		foreach (rows[i]) begin
			in_item_t it;
			it.data_byte = rows[i].b;
			it.first_byte = rows[i].f;
			it.buffer_length = rows[i].len;
			stim.insert(stim.size(), it);
			typed_code.insert(typed_code.size(), rows[i].code);
		end
		while (stim.size() < 1250) make_record();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idx = 0;
		while (idx < stim.size()) begin
			burst = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idx > 600 && !sender_hold && records_sent > 0) begin
				sender_hold = 1'b1;
				in_ch.valid = 1'b0;
				wait (expected_fields.size() == 0);
				@(negedge clk);
			end
			while (burst > 0 && idx < stim.size()) begin
				in_ch.valid = 1'b1;
				in_ch.payload = stim[idx];
				@(posedge clk);
				if (in_ch.ready) begin
					parse_byte(stim[idx]);
					if (typed_code[idx] >= 0 && expected_fields[$].field_code != typed_code[idx]) begin
						$display("%0t table row %0d: expected code %0d, predicted %0d", $time, idx,
							typed_code[idx], expected_fields[$].field_code);
						row_errors++;
					end
					idx++;
					burst--;
				end
				@(negedge clk);
			end
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b0;
		done_stim = 1;
	end

	// receiver stalls
	initial begin
		int pat;
		pat = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pat++;
			if ((pat / 200) % 3 == 2) out_ch.ready = 1'b1;
			else out_ch.ready = ($urandom_range(0, 99) < 65) || (pat % 7 == 0);
		end
	end

	// checker
	always @(posedge clk) begin
		out_item_t exp_f;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			fields_seen++;
			if (expected_fields.size() == 0) begin
				$display("%0t unexpected field: actual %p", $time, out_ch.payload);
				errors++;
			end else begin
				exp_f = expected_fields.pop_front();
				if (out_ch.payload !== exp_f) begin
					$display("%0t mismatch: expected %p, actual %p", $time, exp_f,
						out_ch.payload);
					errors++;
				end
			end
		end
	end

	// watchdog and end of run
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= 5000) begin
				$display("watchdog expired with %0d fields outstanding",
					expected_fields.size());
				$display("tb_face_record_field_parser_core: errors");
				$finish;
			end
			if (done_stim && expected_fields.size() == 0) begin
				repeat (20) @(posedge clk);
				$display("%0d bytes in %0d random records plus directed rows, %0d fields checked",
					stim.size(), records_sent, fields_seen);
				if (errors == 0 && row_errors == 0 && expected_fields.size() == 0)
					$display("tb_face_record_field_parser_core: clean");
				else
					$display("tb_face_record_field_parser_core: errors");
				$finish;
			end
		end
	end

endmodule
